// File: src/bia_pkg.sv
// Shared types, constants and helper functions of the bitmap id allocator.
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  // Identifier space and bitmap geometry
  localparam int ID_COUNT  = 1024;
  localparam int ID_W      = $clog2(ID_COUNT);
  localparam int TOTAL_W   = ID_W + 1;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WORD_CNT  = ID_COUNT / WORD_W;
  localparam int WADDR_W   = $clog2(WORD_CNT);
  localparam int HINT_W    = 32;
  localparam int DIVD_W    = HINT_W - 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0]  WORD_ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0]  WORD_LSB  = WORD_W'(1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(ID_COUNT);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bia_op_t;

  typedef enum logic {
    FIT_FIRST = 1'b0,
    FIT_NEXT  = 1'b1
  } bia_fit_t;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_NO_SPACE = 1'b1
  } bia_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE = 1'b0,
    CFG_ID_TOTAL = 1'b1
  } bia_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } bia_state_t;

  // One read and one write port command to the bitmap store
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_word;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_word;
    logic [WORD_W-1:0]  wr_data;
  } bia_mem_cmd_t;

  // Lowest set bit of a word; zero when the word is empty
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: src/bia_if.sv
// Request and response channel interfaces of the bitmap id allocator.
`timescale 1ns / 1ps
`default_nettype none

interface bia_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bia_pkg::HINT_W-1:0]  start_hint;
  logic [bia_pkg::ID_W-1:0]    free_id;

  modport source (output valid, operation, start_hint, free_id, input ready);
  modport sink   (input valid, operation, start_hint, free_id, output ready);
endinterface

interface bia_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [bia_pkg::ID_W-1:0]    allocated_id;

  modport source (output valid, status, allocated_id, input ready);
  modport sink   (input valid, status, allocated_id, output ready);
endinterface

`default_nettype wire

// File: src/bia_mod_unit.sv
// Iterative restoring remainder unit: hint modulo total, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module bia_mod_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bia_pkg::DIVD_W-1:0]    dividend,
  input  wire logic [bia_pkg::TOTAL_W-1:0]   divisor,
  output logic                               done,
  output logic [bia_pkg::ID_W-1:0]           rem
);

  logic                              run_r, run_nxt;
  logic                              done_r, done_nxt;
  logic [bia_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bia_pkg::DIVD_W-1:0]        quo_r, quo_nxt;
  logic [bia_pkg::ID_W-1:0]          rem_r, rem_nxt;
  logic [bia_pkg::TOTAL_W-1:0]       trial;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, quo_r[bia_pkg::DIVD_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = bia_pkg::DIV_CNT_W'(bia_pkg::DIVD_W - 1);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      quo_nxt = quo_r << 1;
      if (trial >= divisor) begin
        rem_nxt = bia_pkg::ID_W'(trial - divisor);
      end else begin
        rem_nxt = trial[bia_pkg::ID_W-1:0];
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: src/bia_bitmap.sv
// Word-organized store of used marks with one valid bit per word for reset clearing.
`timescale 1ns / 1ps
`default_nettype none

module bia_bitmap (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bia_pkg::bia_mem_cmd_t        cmd,
  output logic [bia_pkg::WORD_W-1:0]        q
);

  logic [bia_pkg::WORD_W-1:0]   mem [bia_pkg::WORD_CNT];
  logic [bia_pkg::WORD_CNT-1:0] row_vld_r, row_vld_nxt;
  logic [bia_pkg::WORD_W-1:0]   q_raw_r;
  logic                         q_vld_r;

  // Mark a word as holding real data once it is written
  always_comb begin
    row_vld_nxt = row_vld_r;
    if (cmd.wr_en) begin
      row_vld_nxt[cmd.wr_word] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else begin
      row_vld_r <= row_vld_nxt;
    end
  end

  // Write and registered read of the store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_word] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      q_raw_r <= mem[cmd.rd_word];
      q_vld_r <= row_vld_r[cmd.rd_word];
    end
  end

  // A word never written since reset reads as all free
  assign q = q_vld_r ? q_raw_r : '0;

endmodule

`default_nettype wire

// File: src/bitmap_id_allocator_unit.sv
// Top level of the bitmap id allocator: sequencer, configuration and response register.
`timescale 1ns / 1ps
`default_nettype none

// Hands out and takes back identifiers from a bitmap of used marks, one request
// at a time. An allocate request first reduces its start hint modulo the
// configured total in a bit-serial remainder unit, then scans the bitmap one
// 32-bit word per cycle through a single registered read port. An allocate
// visits at most 32 words per pass; a next-fit miss adds a second pass. A hint
// of 2^31 or more answers with no space and skips the remainder unit, and a
// free request reads the word, clears the bit, writes it back and responds.
// The bitmap is clear right after reset, with no clearing pass. A new request
// is taken only when the previous one has finished; a finished response waits
// in the output register until taken.
module bitmap_id_allocator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bia_req_if.sink                              in_req,
  bia_rsp_if.source                            out_rsp,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bia_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bia_pkg::TOTAL_W-1:0]     cfg_wr_data
);

  bia_pkg::bia_state_t            state_r, state_nxt;
  bia_pkg::bia_fit_t              fit_mode_r, fit_mode_nxt;
  logic [bia_pkg::TOTAL_W-1:0]    id_total_r, id_total_nxt;
  logic [bia_pkg::TOTAL_W-1:0]    eff_total;
  logic [bia_pkg::ID_W-1:0]       last_id;

  logic [bia_pkg::ID_W-1:0]       cursor_r, cursor_nxt;
  logic [bia_pkg::ID_W-1:0]       start_r, start_nxt;
  logic [bia_pkg::ID_W-1:0]       from_r, from_nxt;
  logic                           retry_r, retry_nxt;
  logic [bia_pkg::ID_W-1:0]       free_id_r, free_id_nxt;
  logic [bia_pkg::WADDR_W-1:0]    rd_word_r, rd_word_nxt;
  logic [bia_pkg::WADDR_W-1:0]    chk_word_r, chk_word_nxt;
  logic                           chk_vld_r, chk_vld_nxt;
  bia_pkg::bia_status_t           res_status_r, res_status_nxt;
  logic [bia_pkg::ID_W-1:0]       res_id_r, res_id_nxt;

  logic                           out_valid_r, out_valid_nxt;
  bia_pkg::bia_status_t           out_status_r, out_status_nxt;
  logic [bia_pkg::ID_W-1:0]       out_id_r, out_id_nxt;

  logic                           in_fire;
  logic                           div_start;
  logic                           div_done;
  logic [bia_pkg::ID_W-1:0]       div_rem;
  bia_pkg::bia_mem_cmd_t          mem_cmd;
  logic [bia_pkg::WORD_W-1:0]     mem_q;
  logic [bia_pkg::WORD_W-1:0]     from_mask;
  logic [bia_pkg::WORD_W-1:0]     top_mask;
  logic [bia_pkg::WORD_W-1:0]     free_bits;
  logic [bia_pkg::BIT_W-1:0]      hit_bit;
  logic [bia_pkg::ID_W-1:0]       div_from;

  // Out-of-range totals act as the full id space
  assign eff_total = (id_total_r == '0 || id_total_r > bia_pkg::TOTAL_MAX) ?
                     bia_pkg::TOTAL_MAX : id_total_r;
  assign last_id   = bia_pkg::ID_W'(eff_total - 1'b1);

  assign in_req.ready = (state_r == bia_pkg::S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.allocated_id = out_id_r;

  bia_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.start_hint[bia_pkg::DIVD_W-1:0]),
    .divisor  (eff_total),
    .done     (div_done),
    .rem      (div_rem)
  );

  bia_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .q     (mem_q)
  );

  // Keep only free marks at or above the scan origin and below the total
  assign from_mask = (chk_word_r == from_r[bia_pkg::ID_W-1:bia_pkg::BIT_W]) ?
                     (bia_pkg::WORD_ONES << from_r[bia_pkg::BIT_W-1:0]) : bia_pkg::WORD_ONES;
  assign top_mask  = (chk_word_r == last_id[bia_pkg::ID_W-1:bia_pkg::BIT_W]) ?
                     (bia_pkg::WORD_ONES >>
                      (bia_pkg::BIT_W'(bia_pkg::WORD_W - 1) - last_id[bia_pkg::BIT_W-1:0])) :
                     bia_pkg::WORD_ONES;
  assign free_bits = ~mem_q & from_mask & top_mask;
  assign hit_bit   = bia_pkg::lowest_set(free_bits);

  // Next-fit begins at the larger of the start point and the cursor
  assign div_from = (fit_mode_r == bia_pkg::FIT_NEXT && cursor_r > div_rem) ?
                    cursor_r : div_rem;

  // Configuration writes
  always_comb begin
    fit_mode_nxt = fit_mode_r;
    id_total_nxt = id_total_r;
    if (cfg_wr_en) begin
      case (bia_pkg::bia_cfg_idx_t'(cfg_index))
        bia_pkg::CFG_FIT_MODE: fit_mode_nxt = bia_pkg::bia_fit_t'(cfg_wr_data[0]);
        bia_pkg::CFG_ID_TOTAL: id_total_nxt = cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, bitmap commands and response
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    start_nxt      = start_r;
    from_nxt       = from_r;
    retry_nxt      = retry_r;
    free_id_nxt    = free_id_r;
    rd_word_nxt    = rd_word_r;
    chk_word_nxt   = chk_word_r;
    chk_vld_nxt    = chk_vld_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    div_start      = 1'b0;
    mem_cmd        = '0;

    case (state_r)
      bia_pkg::S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = bia_pkg::ST_OK;
          res_id_nxt     = '0;
          if (bia_pkg::bia_op_t'(in_req.operation) == bia_pkg::OP_FREE) begin
            free_id_nxt = in_req.free_id;
            if ({1'b0, in_req.free_id} < eff_total) begin
              state_nxt = bia_pkg::S_FREE_RD;
            end else begin
              state_nxt = bia_pkg::S_RESP;
            end
          end else if (in_req.start_hint[bia_pkg::HINT_W-1]) begin
            res_status_nxt = bia_pkg::ST_NO_SPACE;
            state_nxt      = bia_pkg::S_RESP;
          end else begin
            div_start = 1'b1;
            state_nxt = bia_pkg::S_DIV;
          end
        end
      end

      bia_pkg::S_DIV: begin
        if (div_done) begin
          start_nxt   = div_rem;
          chk_vld_nxt = 1'b0;
          if (fit_mode_r == bia_pkg::FIT_NEXT && {1'b0, div_from} >= eff_total) begin
            // Cursor at or beyond the total: the first pass cannot hit, go straight to retry
            cursor_nxt = div_rem;
            from_nxt   = div_rem;
            retry_nxt  = 1'b0;
          end else begin
            from_nxt   = div_from;
            retry_nxt  = (fit_mode_r == bia_pkg::FIT_NEXT);
          end
          rd_word_nxt = from_nxt[bia_pkg::ID_W-1:bia_pkg::BIT_W];
          state_nxt   = bia_pkg::S_SCAN;
        end
      end

      bia_pkg::S_SCAN: begin
        // Stream one word read per cycle, check the word read last cycle
        mem_cmd.rd_en   = 1'b1;
        mem_cmd.rd_word = rd_word_r;
        rd_word_nxt     = rd_word_r + 1'b1;
        chk_word_nxt    = rd_word_r;
        chk_vld_nxt     = 1'b1;
        if (chk_vld_r) begin
          if (|free_bits) begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_word = chk_word_r;
            mem_cmd.wr_data = mem_q | (bia_pkg::WORD_LSB << hit_bit);
            cursor_nxt      = {chk_word_r, hit_bit};
            res_status_nxt  = bia_pkg::ST_OK;
            res_id_nxt      = {chk_word_r, hit_bit};
            state_nxt       = bia_pkg::S_RESP;
          end else if (chk_word_r == last_id[bia_pkg::ID_W-1:bia_pkg::BIT_W]) begin
            if (retry_r) begin
              cursor_nxt  = start_r;
              from_nxt    = start_r;
              retry_nxt   = 1'b0;
              rd_word_nxt = start_r[bia_pkg::ID_W-1:bia_pkg::BIT_W];
              chk_vld_nxt = 1'b0;
            end else begin
              res_status_nxt = bia_pkg::ST_NO_SPACE;
              res_id_nxt     = '0;
              state_nxt      = bia_pkg::S_RESP;
            end
          end
        end
      end

      bia_pkg::S_FREE_RD: begin
        mem_cmd.rd_en   = 1'b1;
        mem_cmd.rd_word = free_id_r[bia_pkg::ID_W-1:bia_pkg::BIT_W];
        state_nxt       = bia_pkg::S_FREE_WR;
      end

      bia_pkg::S_FREE_WR: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_word = free_id_r[bia_pkg::ID_W-1:bia_pkg::BIT_W];
        mem_cmd.wr_data = mem_q & ~(bia_pkg::WORD_LSB << free_id_r[bia_pkg::BIT_W-1:0]);
        state_nxt       = bia_pkg::S_RESP;
      end

      bia_pkg::S_RESP: begin
        // Hold until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = bia_pkg::S_IDLE;
        end
      end

      default: state_nxt = bia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bia_pkg::S_IDLE;
      fit_mode_r  <= bia_pkg::FIT_FIRST;
      id_total_r  <= bia_pkg::TOTAL_MAX;
      cursor_r    <= '0;
      chk_vld_r   <= 1'b0;
      retry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fit_mode_r  <= fit_mode_nxt;
      id_total_r  <= id_total_nxt;
      cursor_r    <= cursor_nxt;
      chk_vld_r   <= chk_vld_nxt;
      retry_r     <= retry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    from_r       <= from_nxt;
    free_id_r    <= free_id_nxt;
    rd_word_r    <= rd_word_nxt;
    chk_word_r   <= chk_word_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  // A new response is loaded only from the response state
  a_resp_from_resp_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == bia_pkg::S_RESP)
    else $error("response raised outside the response state");

  // A failed request never carries an identifier
  a_no_space_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == bia_pkg::ST_NO_SPACE) |-> out_id_r == '0)
    else $error("no-space response with nonzero id");

  // Bitmap writes come only from a scan hit or a free update
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.wr_en |-> (state_r == bia_pkg::S_SCAN || state_r == bia_pkg::S_FREE_WR))
    else $error("bitmap written outside scan or free");

  // The remainder unit finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == bia_pkg::S_DIV)
    else $error("remainder done outside divide state");

endmodule

`default_nettype wire
